FILE: hw/rtl/bsse_pkg.sv
package bsse_pkg;

  // Geometry of the bit vector.
  localparam int CAPACITY_BITS = 4096;
  localparam int WORD_BITS     = 64;
  localparam int NUM_WORDS     = CAPACITY_BITS / WORD_BITS;
  localparam int WADDR_W       = $clog2(NUM_WORDS);
  localparam int BSEL_W        = $clog2(WORD_BITS);
  localparam int IDX_W         = 13;
  localparam int POS_W         = 12;
  localparam int CNT_W         = 13;
  localparam int POP_W         = $clog2(WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0] word_t;

  // Operation codes carried by an input transfer.
  typedef enum logic [3:0] {
    OP_TEST      = 4'd0,
    OP_SET       = 4'd1,
    OP_CLEAR     = 4'd2,
    OP_NEXT      = 4'd3,
    OP_PREV      = 4'd4,
    OP_COUNT     = 4'd5,
    OP_CLEAR_ALL = 4'd6,
    OP_SET_ALL   = 4'd7,
    OP_SET_SIZE  = 4'd8
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0]       operation;
    logic [IDX_W-1:0] bit_index;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             bit_value;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] set_count;
  } out_t;

  // Request from the sequencer to the word store.
  typedef struct packed {
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [WADDR_W-1:0] wr_addr;
    word_t              wr_data;
    logic               inv_all;
    logic               inv_above;
    logic [WADDR_W-1:0] inv_addr;
  } mem_req_t;

  // Bit window handed to the shared word unit.
  typedef struct packed {
    logic [BSEL_W-1:0] lo_bit;
    logic [BSEL_W-1:0] hi_bit;
  } wu_req_t;

  // What the word unit finds inside the window.
  typedef struct packed {
    logic              hit;
    logic [BSEL_W-1:0] first;
    logic [BSEL_W-1:0] last;
    logic [POP_W-1:0]  ones;
  } wu_rsp_t;

  // Population count of one word by pairwise folding of bit fields.
  function automatic logic [POP_W-1:0] pop_word(input word_t w);
    word_t x;
    x = w - ((w >> 1) & {2{32'h55555555}});
    x = (x & {2{32'h33333333}}) + ((x >> 2) & {2{32'h33333333}});
    x = (x + (x >> 4)) & {2{32'h0F0F0F0F}};
    x = x + (x >> 8);
    x = x + (x >> 16);
    x = x + (x >> 32);
    return x[POP_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/bsse_mem.sv
module bsse_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  bsse_pkg::mem_req_t req,
  output bsse_pkg::word_t    rd_data
);
  import bsse_pkg::*;

  word_t                mem_r [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid_r;
  word_t                q_r;
  logic                 q_valid_r;

  // Word storage with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      q_r <= mem_r[req.rd_addr];
    end
  end

  // Per-word valid bits: a word that is not valid reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (req.inv_all) begin
        valid_r <= '0;
      end else if (req.inv_above) begin
        for (int w = 0; w < NUM_WORDS; w++) begin
          if (WADDR_W'(w) > req.inv_addr) begin
            valid_r[w] <= 1'b0;
          end
        end
      end
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        q_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = q_valid_r ? q_r : '0;

endmodule

FILE: hw/rtl/bsse_word_unit.sv
module bsse_word_unit (
  input  bsse_pkg::word_t   word,
  input  bsse_pkg::wu_req_t req,
  output bsse_pkg::wu_rsp_t rsp
);
  import bsse_pkg::*;

  word_t lo_mask;
  word_t hi_mask;
  word_t masked;

  // Keep only the bits inside the requested window.
  assign lo_mask = {WORD_BITS{1'b1}} << req.lo_bit;
  assign hi_mask = {WORD_BITS{1'b1}} >> (BSEL_W'(WORD_BITS - 1) - req.hi_bit);
  assign masked  = word & lo_mask & hi_mask;

  // Lowest and highest set bit, any-hit flag and population count.
  always_comb begin
    rsp.first = '0;
    rsp.last  = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (masked[i]) begin
        rsp.first = BSEL_W'(i);
      end
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      if (masked[i]) begin
        rsp.last = BSEL_W'(i);
      end
    end
    rsp.hit  = |masked;
    rsp.ones = pop_word(masked);
  end

endmodule

FILE: hw/rtl/bsse_seq.sv
module bsse_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bsse_pkg::in_t      in_data,
  output logic               busy,
  output logic               out_valid,
  output bsse_pkg::out_t     out_data,
  output bsse_pkg::mem_req_t mem_req,
  input  bsse_pkg::word_t    rd_data,
  output bsse_pkg::wu_req_t  wu_req,
  input  bsse_pkg::wu_rsp_t  wu_rsp
);
  import bsse_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_MODIFY   = 5'b00100,
    S_SCAN     = 5'b01000,
    S_FILL     = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [3:0]         op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   len_r, len_nxt;
  logic [WADDR_W-1:0] cur_w_r, cur_w_nxt;
  logic               first_r, first_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r;
  out_t               out_data_r;
  logic               fin;
  out_t               fin_data;

  logic [WADDR_W-1:0] idx_word;
  logic [BSEL_W-1:0]  idx_bit;
  logic               idx_over;
  logic               size_over;
  logic               in_len;
  logic [IDX_W-1:0]   len_m1;
  logic [WADDR_W-1:0] last_w;
  logic [BSEL_W-1:0]  len_bit;
  word_t              bit_onehot;
  word_t              idx_keep;
  word_t              fill_last;
  logic [CNT_W-1:0]   cnt_sum;

  // Values derived from the held index and the length.
  assign idx_word   = idx_r[BSEL_W +: WADDR_W];
  assign idx_bit    = idx_r[BSEL_W-1:0];
  assign idx_over   = idx_r >= IDX_W'(CAPACITY_BITS);
  assign size_over  = idx_r > IDX_W'(CAPACITY_BITS);
  assign in_len     = idx_r < len_r;
  assign len_m1     = len_r - IDX_W'(1);
  assign last_w     = len_m1[BSEL_W +: WADDR_W];
  assign len_bit    = len_r[BSEL_W-1:0];
  assign bit_onehot = word_t'(1) << idx_bit;
  assign idx_keep   = bit_onehot - word_t'(1);
  assign fill_last  = (len_bit == '0) ? {WORD_BITS{1'b1}}
                                      : ((word_t'(1) << len_bit) - word_t'(1));
  assign cnt_sum    = cnt_r + CNT_W'(wu_rsp.ones);

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer: dispatch, one read-modify-write, or a walk over the words.
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    cur_w_nxt     = cur_w_r;
    first_nxt     = first_r;
    cnt_nxt       = cnt_r;
    fin           = 1'b0;
    fin_data      = '0;
    mem_req       = '0;
    wu_req.lo_bit = '0;
    wu_req.hi_bit = BSEL_W'(WORD_BITS - 1);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        cur_w_nxt = idx_word;
        first_nxt = 1'b1;
        cnt_nxt   = '0;
        unique case (op_r) inside
          OP_TEST, OP_SET, OP_CLEAR: begin
            if (idx_over) begin
              fin             = 1'b1;
              fin_data.status = ST_RANGE;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = idx_word;
              state_nxt       = S_MODIFY;
            end
          end
          OP_NEXT, OP_PREV: begin
            if (idx_over) begin
              fin             = 1'b1;
              fin_data.status = ST_RANGE;
            end else if (!in_len) begin
              fin             = 1'b1;
              fin_data.status = ST_NONE;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = idx_word;
              state_nxt       = S_SCAN;
            end
          end
          OP_COUNT: begin
            cur_w_nxt       = '0;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = '0;
            state_nxt       = S_SCAN;
          end
          OP_CLEAR_ALL: begin
            mem_req.inv_all = 1'b1;
            fin             = 1'b1;
          end
          OP_SET_ALL: begin
            cur_w_nxt = '0;
            if (len_r == '0) begin
              fin = 1'b1;
            end else begin
              state_nxt = S_FILL;
            end
          end
          OP_SET_SIZE: begin
            if (size_over) begin
              fin             = 1'b1;
              fin_data.status = ST_RANGE;
            end else if (!in_len) begin
              len_nxt = idx_r;
              fin     = 1'b1;
            end else begin
              // Words above the word of the new length are dropped at once.
              mem_req.rd_en     = 1'b1;
              mem_req.rd_addr   = idx_word;
              mem_req.inv_above = 1'b1;
              mem_req.inv_addr  = idx_word;
              state_nxt         = S_MODIFY;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
        if (fin) begin
          state_nxt = S_IDLE;
        end
      end

      S_MODIFY: begin
        fin             = 1'b1;
        state_nxt       = S_IDLE;
        mem_req.wr_addr = idx_word;
        unique case (op_r) inside
          OP_TEST: begin
            fin_data.bit_value = rd_data[idx_bit];
          end
          OP_SET: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = rd_data | bit_onehot;
            if (!in_len) begin
              len_nxt = idx_r + IDX_W'(1);
            end
          end
          OP_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = rd_data & ~bit_onehot;
          end
          OP_SET_SIZE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = rd_data & idx_keep;
            len_nxt         = idx_r;
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        // The next word is read while the current one is examined.
        first_nxt     = 1'b0;
        mem_req.rd_en = 1'b1;
        unique case (op_r) inside
          OP_NEXT: begin
            wu_req.lo_bit   = first_r ? idx_bit : '0;
            mem_req.rd_addr = cur_w_r + WADDR_W'(1);
            if (wu_rsp.hit) begin
              fin               = 1'b1;
              fin_data.position = {cur_w_r, wu_rsp.first};
            end else if (cur_w_r == WADDR_W'(NUM_WORDS - 1)) begin
              fin             = 1'b1;
              fin_data.status = ST_NONE;
            end else begin
              cur_w_nxt = cur_w_r + WADDR_W'(1);
            end
          end
          OP_PREV: begin
            wu_req.hi_bit   = first_r ? idx_bit : BSEL_W'(WORD_BITS - 1);
            mem_req.rd_addr = cur_w_r - WADDR_W'(1);
            if (wu_rsp.hit) begin
              fin               = 1'b1;
              fin_data.position = {cur_w_r, wu_rsp.last};
            end else if (cur_w_r == '0) begin
              fin             = 1'b1;
              fin_data.status = ST_NONE;
            end else begin
              cur_w_nxt = cur_w_r - WADDR_W'(1);
            end
          end
          OP_COUNT: begin
            mem_req.rd_addr = cur_w_r + WADDR_W'(1);
            cnt_nxt         = cnt_sum;
            if (cur_w_r == WADDR_W'(NUM_WORDS - 1)) begin
              fin                = 1'b1;
              fin_data.set_count = cnt_sum;
            end else begin
              cur_w_nxt = cur_w_r + WADDR_W'(1);
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
        if (fin) begin
          state_nxt = S_IDLE;
        end
      end

      S_FILL: begin
        // Whole words below the last word, then the last word up to the length.
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = cur_w_r;
        if (cur_w_r == last_w) begin
          mem_req.wr_data = fill_last;
          fin             = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          mem_req.wr_data = {WORD_BITS{1'b1}};
          cur_w_nxt       = cur_w_r + WADDR_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= fin;
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r  <= in_data.operation;
      idx_r <= in_data.bit_index;
    end
    cur_w_r <= cur_w_nxt;
    first_r <= first_nxt;
    cnt_r   <= cnt_nxt;
    if (fin) begin
      out_data_r <= fin_data;
    end
  end

  // The length moves only when an operation completes.
  a_len_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(len_r) |-> out_valid_r)
    else $error("length changed without a result transfer");

  // A result is only ever produced by an item in progress.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy))
    else $error("result strobe without an item in progress");

  // The store is never written while the block is idle.
  a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> busy)
    else $error("word store written while idle");

  // An accepted transfer always enters dispatch next.
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_DISPATCH))
    else $error("accepted item did not reach dispatch");

  // A running count never exceeds the bits in the words already visited.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && (op_r == OP_COUNT))
      |-> (cnt_r <= CNT_W'({cur_w_r, {BSEL_W{1'b0}}})))
    else $error("running count exceeds visited bits");

endmodule

FILE: hw/rtl/bitmap_set_scan_engine_unit.sv
// Range errors, unknown codes, clear all and length-only changes finish in dispatch; test,
// set, clear and shrinking resize go on to modify. Next and previous walk from the index word
// and count walks all 64 words, one per cycle through the single read port of the word store;
// set all writes words up to the last one, one per cycle, through the write port. busy falls
// as the strobe rises; the next item is accepted at the edge ending the strobe. No stalls.
// Synchronous reset empties the bitmap at once through per-word valid bits; length goes to 0.
module bitmap_set_scan_engine_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  bsse_pkg::in_t  in_data,
  output logic           busy,
  output logic           out_valid,
  output bsse_pkg::out_t out_data
);
  import bsse_pkg::*;

  mem_req_t mem_req;
  word_t    rd_data;
  wu_req_t  wu_req;
  wu_rsp_t  wu_rsp;

  // Word store.
  bsse_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Shared search and population count unit.
  bsse_word_unit u_word_unit (
    .word (rd_data),
    .req  (wu_req),
    .rsp  (wu_rsp)
  );

  // Operation sequencer.
  bsse_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .wu_req    (wu_req),
    .wu_rsp    (wu_rsp)
  );

endmodule
